[src/jpeg_ssd_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// jpeg_ssd_pkg
// Types, constants and Huffman tables shared by the subsampling detector.
// ---------------------------------------------------------------------------
package jpeg_ssd_pkg;

  localparam int LumaBlocksADefault = 4;
  localparam int LumaBlocksBDefault = 2;
  localparam logic [15:0] McuLimitReset = 16'd10000;
  localparam logic [7:0] MarkerByte = 8'hFF;
  localparam logic [7:0] StuffByte = 8'h00;
  localparam logic [6:0] LastCoef = 7'd63;
  localparam logic [8:0] DcSymCount = 9'd12;
  localparam logic [8:0] AcSymCount = 9'd162;
  localparam int CfgAddrWidth = 3;
  localparam logic [0:0] RegMcuLimit = 1'b0;

  typedef enum logic [1:0] {
    PH_DC_SYM   = 2'd0,
    PH_DC_EXTRA = 2'd1,
    PH_AC_SYM   = 2'd2,
    PH_AC_EXTRA = 2'd3
  } phase_t;

  typedef struct packed {
    logic [15:0] code_bits;
    logic [4:0]  code_length;
    logic [16:0] first_code_value;
    logic [7:0]  symbol_index;
    phase_t      decode_phase;
    logic [3:0]  extra_bits_left;
    logic [6:0]  coefficient_index;
    logic [2:0]  block_in_mcu;
    logic [15:0] mcu_tally;
  } dec_state_t;

  // Code-length counts: DC luma, DC chroma, AC luma, AC chroma.
  localparam logic [7:0] LEN_COUNTS [4][16] = '{
    '{8'd0, 8'd1, 8'd5, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
      8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd0, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
      8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd0, 8'd2, 8'd1, 8'd3, 8'd3, 8'd2, 8'd4, 8'd3,
      8'd5, 8'd5, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'h7D},
    '{8'd0, 8'd2, 8'd1, 8'd2, 8'd4, 8'd4, 8'd3, 8'd4,
      8'd7, 8'd5, 8'd4, 8'd4, 8'd0, 8'd1, 8'd2, 8'h77}
  };

  localparam logic [7:0] AC_SYMS [2][162] = '{
    '{8'h01, 8'h02, 8'h03, 8'h00, 8'h04, 8'h11, 8'h05, 8'h12, 8'h21, 8'h31, 8'h41,
      8'h06, 8'h13, 8'h51, 8'h61, 8'h07, 8'h22, 8'h71, 8'h14, 8'h32, 8'h81, 8'h91,
      8'hA1, 8'h08, 8'h23, 8'h42, 8'hB1, 8'hC1, 8'h15, 8'h52, 8'hD1, 8'hF0, 8'h24,
      8'h33, 8'h62, 8'h72, 8'h82, 8'h09, 8'h0A, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A,
      8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
      8'h39, 8'h3A, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A, 8'h53,
      8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A, 8'h63, 8'h64, 8'h65, 8'h66,
      8'h67, 8'h68, 8'h69, 8'h6A, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79,
      8'h7A, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8A, 8'h92, 8'h93,
      8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9A, 8'hA2, 8'hA3, 8'hA4, 8'hA5,
      8'hA6, 8'hA7, 8'hA8, 8'hA9, 8'hAA, 8'hB2, 8'hB3, 8'hB4, 8'hB5, 8'hB6, 8'hB7,
      8'hB8, 8'hB9, 8'hBA, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7, 8'hC8, 8'hC9,
      8'hCA, 8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hD6, 8'hD7, 8'hD8, 8'hD9, 8'hDA, 8'hE1,
      8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6, 8'hE7, 8'hE8, 8'hE9, 8'hEA, 8'hF1, 8'hF2,
      8'hF3, 8'hF4, 8'hF5, 8'hF6, 8'hF7, 8'hF8, 8'hF9, 8'hFA},
    '{8'h00, 8'h01, 8'h02, 8'h03, 8'h11, 8'h04, 8'h05, 8'h21, 8'h31, 8'h06, 8'h12,
      8'h41, 8'h51, 8'h07, 8'h61, 8'h71, 8'h13, 8'h22, 8'h32, 8'h81, 8'h08, 8'h14,
      8'h42, 8'h91, 8'hA1, 8'hB1, 8'hC1, 8'h09, 8'h23, 8'h33, 8'h52, 8'hF0, 8'h15,
      8'h62, 8'h72, 8'hD1, 8'h0A, 8'h16, 8'h24, 8'h34, 8'hE1, 8'h25, 8'hF1, 8'h17,
      8'h18, 8'h19, 8'h1A, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h3A, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
      8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A, 8'h63, 8'h64, 8'h65,
      8'h66, 8'h67, 8'h68, 8'h69, 8'h6A, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78,
      8'h79, 8'h7A, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8A,
      8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9A, 8'hA2, 8'hA3,
      8'hA4, 8'hA5, 8'hA6, 8'hA7, 8'hA8, 8'hA9, 8'hAA, 8'hB2, 8'hB3, 8'hB4, 8'hB5,
      8'hB6, 8'hB7, 8'hB8, 8'hB9, 8'hBA, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7,
      8'hC8, 8'hC9, 8'hCA, 8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hD6, 8'hD7, 8'hD8, 8'hD9,
      8'hDA, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6, 8'hE7, 8'hE8, 8'hE9, 8'hEA, 8'hF2,
      8'hF3, 8'hF4, 8'hF5, 8'hF6, 8'hF7, 8'hF8, 8'hF9, 8'hFA}
  };

endpackage
`default_nettype wire

[src/jpeg_subsampling_detector.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// jpeg_subsampling_detector
// Checks a baseline JPEG scan against 4:2:0 and 4:2:2 MCU layouts.
// ---------------------------------------------------------------------------
// Scan bytes arrive on the s_axis channel, one per transfer, tlast on the
// final byte of the scan. FF 00 pairs are unstuffed; any other byte after FF,
// or FF as the last byte, stops both decoders. Two Huffman decoders share
// one two-entry state memory with a registered read; each bit step is a read
// state and an execute state that writes the entry back unless that decoder
// is stopped or at its MCU limit, decoder A then decoder B. A data byte is
// taken in the idle state, then its bits, MSB first, are stepped through both
// decoders while s_axis is not ready; a held FF feeds no bits. After the last
// byte, the states T0, T1 and T2 read both tallies and OUT loads the report
// into the output register, which then shows on m_axis until taken. s_axis
// is ready again as soon as the report is loaded; if the previous report
// still waits when the next one is done, the block holds until it is taken.
// Reset clears the control state and marks both memory entries as holding the
// reset state; mcu_limit returns to 10000. The user writes the limit over the
// APB port at byte address 0 while the block is idle; it is not checked.
// ---------------------------------------------------------------------------
module jpeg_subsampling_detector #(
  parameter int LUMA_BLOCKS_A = jpeg_ssd_pkg::LumaBlocksADefault,
  parameter int LUMA_BLOCKS_B = jpeg_ssd_pkg::LumaBlocksBDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // scan_byte
  input  wire logic s_axis_tlast,        // last_byte
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // count_four_luma [15:0], count_two_luma [31:16], is_four_two_zero [32]
  output logic [39:0] m_axis_tdata,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [jpeg_ssd_pkg::CfgAddrWidth-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import jpeg_ssd_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RD   = 7'b0000010,
    ST_EX   = 7'b0000100,
    ST_T0   = 7'b0001000,
    ST_T1   = 7'b0010000,
    ST_T2   = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  localparam logic [2:0] LumaA = 3'(LUMA_BLOCKS_A);
  localparam logic [2:0] LumaB = 3'(LUMA_BLOCKS_B);

  state_t      state;
  logic [15:0] mcu_limit;
  logic [7:0]  held_byte;
  logic        awaiting_stuff_byte;
  logic [1:0]  decoder_stopped;
  logic [1:0]  entry_valid;
  logic [7:0]  bit_byte;
  logic [2:0]  bit_pos;
  logic        dec;
  logic        scan_last;
  logic [15:0] tally_a;
  logic [15:0] tally_b;

  dec_state_t  mem [2];
  dec_state_t  rd_data;
  logic        rd_valid;
  logic        rd_addr;
  logic        wr_en;
  dec_state_t  wr_data;
  logic        stop_now;

  logic        cfg_wr;
  logic        in_go;
  logic        out_go;
  logic        feed;
  logic [7:0]  feed_val;
  logic        kill_all;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[CfgAddrWidth-1] == RegMcuLimit) ? {16'd0, mcu_limit} : 32'd0;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_go = s_axis_tvalid && s_axis_tready;
  assign out_go = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

  // Byte unstuffing decision for the byte being taken.
  always_comb begin
    feed = 1'b0;
    feed_val = s_axis_tdata;
    kill_all = 1'b0;
    if (awaiting_stuff_byte) begin
      if (s_axis_tdata == StuffByte) begin
        feed = 1'b1;
        feed_val = held_byte;
      end else begin
        kill_all = 1'b1;
      end
    end else if (s_axis_tdata == MarkerByte) begin
      kill_all = s_axis_tlast;
    end else begin
      feed = 1'b1;
    end
  end

  always_comb begin
    rd_addr = dec;
    if (state == ST_T0) begin
      rd_addr = 1'b0;
    end else if (state == ST_T1) begin
      rd_addr = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[dec] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // One bit step of the decoder whose entry was just read.
  always_comb begin
    dec_state_t s;
    dec_state_t n;
    logic [2:0]  luma;
    logic        chroma;
    logic        bitv;
    logic [4:0]  clen;
    logic [15:0] code;
    logic [7:0]  count;
    logic [16:0] diff;
    logic        match;
    logic [8:0]  idx;
    logic        idx_ok;
    logic [7:0]  sym;
    logic        is_ac;
    logic        sym_done;
    logic        fail;
    logic [6:0]  coef;
    logic        finish;
    logic        after;
    s = rd_valid ? rd_data : '0;
    n = s;
    luma = dec ? LumaB : LumaA;
    chroma = (s.block_in_mcu >= luma);
    bitv = bit_byte[bit_pos];
    is_ac = (s.decode_phase == PH_AC_SYM);
    clen = {1'b0, s.code_length[3:0]} + 5'd1;
    code = {s.code_bits[14:0], bitv};
    count = LEN_COUNTS[{is_ac, chroma}][4'(clen - 5'd1)];
    diff = {1'b0, code} - s.first_code_value;
    match = (count != 8'd0) && ({1'b0, code} >= s.first_code_value)
            && (diff < {9'd0, count});
    idx = {1'b0, s.symbol_index} + {1'b0, diff[7:0]};
    idx_ok = is_ac ? (idx < AcSymCount) : (idx < DcSymCount);
    sym = is_ac ? AC_SYMS[chroma][idx[7:0]] : idx[7:0];
    sym_done = match && idx_ok;
    fail = 1'b0;
    finish = 1'b0;
    after = 1'b0;
    coef = s.coefficient_index + {3'd0, sym[7:4]} + 7'd1;
    if (s.decode_phase == PH_DC_SYM || s.decode_phase == PH_AC_SYM) begin
      if (match || clen >= 5'd16) begin
        n.code_bits = '0;
        n.code_length = '0;
        n.first_code_value = '0;
        n.symbol_index = '0;
        fail = !sym_done;
      end else begin
        n.code_bits = code;
        n.code_length = clen;
        n.symbol_index = s.symbol_index + count;
        n.first_code_value = {s.first_code_value[15:0] + {8'd0, count}, 1'b0};
      end
    end
    unique case (s.decode_phase)
      PH_DC_SYM: begin
        if (sym_done) begin
          n.coefficient_index = '0;
          if (sym != 8'd0) begin
            n.extra_bits_left = sym[3:0];
            n.decode_phase = PH_DC_EXTRA;
          end else begin
            n.decode_phase = PH_AC_SYM;
          end
        end
      end
      PH_DC_EXTRA: begin
        n.extra_bits_left = s.extra_bits_left - 4'd1;
        if (n.extra_bits_left == 4'd0) begin
          n.decode_phase = PH_AC_SYM;
        end
      end
      PH_AC_SYM: begin
        if (sym_done) begin
          if (sym == 8'd0) begin
            finish = 1'b1;
          end else begin
            n.coefficient_index = coef;
            if (coef > LastCoef) begin
              fail = 1'b1;
            end else if (sym[3:0] != 4'd0) begin
              n.extra_bits_left = sym[3:0];
              n.decode_phase = PH_AC_EXTRA;
            end else begin
              after = 1'b1;
            end
          end
        end
      end
      PH_AC_EXTRA: begin
        n.extra_bits_left = s.extra_bits_left - 4'd1;
        after = (n.extra_bits_left == 4'd0);
      end
      default: begin
      end
    endcase
    if (after) begin
      if (n.coefficient_index >= LastCoef) begin
        finish = 1'b1;
      end else begin
        n.decode_phase = PH_AC_SYM;
      end
    end
    if (finish) begin
      n.block_in_mcu = s.block_in_mcu + 3'd1;
      if (n.block_in_mcu >= luma + 3'd2) begin
        n.block_in_mcu = '0;
        n.mcu_tally = s.mcu_tally + 16'd1;
      end
      n.decode_phase = PH_DC_SYM;
      n.coefficient_index = '0;
    end
    wr_en = (state == ST_EX) && !decoder_stopped[dec] && (s.mcu_tally < mcu_limit);
    wr_data = n;
    stop_now = wr_en && fail;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mcu_limit <= McuLimitReset;
      held_byte <= '0;
      awaiting_stuff_byte <= 1'b0;
      decoder_stopped <= '0;
      entry_valid <= '0;
      rd_valid <= 1'b0;
      bit_pos <= '0;
      dec <= 1'b0;
      scan_last <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      rd_valid <= entry_valid[rd_addr];
      if (cfg_wr && paddr[CfgAddrWidth-1] == RegMcuLimit) begin
        mcu_limit <= pwdata[15:0];
      end
      if (out_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (wr_en) begin
        entry_valid[dec] <= 1'b1;
      end
      if (stop_now) begin
        decoder_stopped[dec] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_go) begin
            scan_last <= s_axis_tlast;
            held_byte <= s_axis_tdata;
            awaiting_stuff_byte <= !awaiting_stuff_byte
                                   && (s_axis_tdata == MarkerByte) && !s_axis_tlast;
            if (kill_all) begin
              decoder_stopped <= 2'b11;
            end
            bit_byte <= feed_val;
            bit_pos <= 3'd7;
            dec <= 1'b0;
            if (feed) begin
              state <= ST_RD;
            end else if (s_axis_tlast) begin
              state <= ST_T0;
            end
          end
        end
        ST_RD: state <= ST_EX;
        ST_EX: begin
          dec <= !dec;
          if (!dec) begin
            state <= ST_RD;
          end else if (bit_pos != 3'd0) begin
            bit_pos <= bit_pos - 3'd1;
            state <= ST_RD;
          end else begin
            state <= scan_last ? ST_T0 : ST_IDLE;
          end
        end
        ST_T0: state <= ST_T1;
        ST_T1: begin
          tally_a <= rd_valid ? rd_data.mcu_tally : 16'd0;
          state <= ST_T2;
        end
        ST_T2: begin
          tally_b <= rd_valid ? rd_data.mcu_tally : 16'd0;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_go) begin
            entry_valid <= '0;
            decoder_stopped <= '0;
            held_byte <= '0;
            awaiting_stuff_byte <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_go) begin
      m_axis_tdata <= {7'd0, tally_a > tally_b, tally_b, tally_a};
    end
  end

`ifndef ASSERT_OFF
  // The report's choice must agree with the two counts it carries.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[32] == (m_axis_tdata[15:0] > m_axis_tdata[31:16])))
    else $error("subsampling choice disagrees with counts");
  // Loading a report starts a new scan with both entries at their reset state.
  assert property (@(posedge clk) disable iff (rst)
    out_go |=> (entry_valid == 2'b00) && (decoder_stopped == 2'b00))
    else $error("scan state not cleared after report");
  // The state memory is written only in an execute cycle.
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_EX) && $past(state == ST_RD))
    else $error("state memory written outside a bit step");
`endif

endmodule
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the JPEG subsampling detector.
// ---------------------------------------------------------------------------
// Scan bytes are sent over the slave stream, and every report on the master
// stream is compared with a bit-level model of both Huffman decoders. A short
// table of hand-made scans comes first. Random scans follow, mostly built
// from real Huffman codes for 4:2:0 or 4:2:2 layouts, some for one or three
// luma blocks; some have flipped bits, cut-off tails or bad markers, some are
// plain noise. The MCU limit and both sides' idle patterns change per phase.
// ---------------------------------------------------------------------------
module testbench;
  import jpeg_ssd_pkg::*;

  typedef struct {
    logic [15:0] four;
    logic [15:0] two;
    logic        pick;
  } report_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       typed;
    report_t    rep;
  } row_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata;   // scan_byte
  logic s_axis_tlast;         // last_byte
  logic m_axis_tvalid;
  logic m_axis_tready;
  // count_four_luma [15:0], count_two_luma [31:16], is_four_two_zero [32]
  logic [39:0] m_axis_tdata;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CfgAddrWidth-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  jpeg_subsampling_detector DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Decoder model state, index 0 is the four-luma decoder.
  int     limit_now;
  int     held;
  bit     await_stuff;
  int     cbits[2];
  int     clen[2];
  int     fcode[2];
  int     sidx[2];
  phase_t ph[2];
  int     xleft[2];
  int     coef[2];
  int     blk[2];
  int     tally[2];
  bit     halted[2];

  report_t reports_due[$];
  row_t    plan[$];
  bit      stream_bits[$];
  logic [7:0] scan_q[$];

  int errors;
  int snd_idle;
  int rcv_idle;
  bit hold_go;
  logic holding;
  int quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_search(int d);
    cbits[d] = 0;
    clen[d] = 0;
    fcode[d] = 0;
    sidx[d] = 0;
  endfunction

  function automatic void start_scan();
    held = 0;
    await_stuff = 0;
    for (int d = 0; d < 2; d++) begin
      clear_search(d);
      ph[d] = PH_DC_SYM;
      xleft[d] = 0;
      coef[d] = 0;
      blk[d] = 0;
      tally[d] = 0;
      halted[d] = 0;
    end
  endfunction

  // One bit of canonical Huffman search: symbol, -1 while pending, -2 on a miss.
  function automatic int huff_step(int d, bit b, int tbl);
    int len;
    int code;
    int cnt;
    int fst;
    int idx;
    len = (clen[d] & 15) + 1;
    code = ((cbits[d] << 1) | b) & 16'hFFFF;
    cnt = LEN_COUNTS[tbl][len-1];
    fst = fcode[d];
    if (cnt > 0 && code >= fst && code - fst < cnt) begin
      idx = sidx[d] + (code - fst);
      clear_search(d);
      if (tbl < 2) return (idx < 12) ? idx : -2;
      return (idx < 162) ? int'(AC_SYMS[tbl-2][idx]) : -2;
    end
    if (len >= 16) begin
      clear_search(d);
      return -2;
    end
    cbits[d] = code;
    clen[d] = len;
    sidx[d] = (sidx[d] + cnt) & 8'hFF;
    fcode[d] = ((fst + cnt) << 1) & 17'h1FFFF;
    return -1;
  endfunction

  function automatic void close_block(int d, int luma);
    blk[d] = (blk[d] + 1) & 7;
    if (blk[d] >= luma + 2) begin
      blk[d] = 0;
      tally[d] = (tally[d] + 1) & 16'hFFFF;
    end
    ph[d] = PH_DC_SYM;
    coef[d] = 0;
  endfunction

  function automatic void after_coef(int d, int luma);
    if (coef[d] >= 63) close_block(d, luma);
    else ph[d] = PH_AC_SYM;
  endfunction

  function automatic void decode_bit(int d, bit b, int luma);
    int chroma;
    int sym;
    chroma = (blk[d] >= luma) ? 1 : 0;
    case (ph[d])
      PH_DC_SYM: begin
        sym = huff_step(d, b, chroma);
        if (sym == -2) begin
          halted[d] = 1;
        end else if (sym >= 0) begin
          coef[d] = 0;
          if (sym > 0) begin
            xleft[d] = sym & 15;
            ph[d] = PH_DC_EXTRA;
          end else begin
            ph[d] = PH_AC_SYM;
          end
        end
      end
      PH_DC_EXTRA: begin
        xleft[d] = (xleft[d] - 1) & 15;
        if (xleft[d] == 0) ph[d] = PH_AC_SYM;
      end
      PH_AC_SYM: begin
        sym = huff_step(d, b, 2 + chroma);
        if (sym == -2) begin
          halted[d] = 1;
        end else if (sym == 0) begin
          close_block(d, luma);
        end else if (sym > 0) begin
          coef[d] = (coef[d] + ((sym >> 4) & 15) + 1) & 7'h7F;
          if (coef[d] > 63) begin
            halted[d] = 1;
          end else if ((sym & 15) > 0) begin
            xleft[d] = sym & 15;
            ph[d] = PH_AC_EXTRA;
          end else begin
            after_coef(d, luma);
          end
        end
      end
      default: begin
        xleft[d] = (xleft[d] - 1) & 15;
        if (xleft[d] == 0) after_coef(d, luma);
      end
    endcase
  endfunction

  function automatic void feed_bits(logic [7:0] v);
    for (int p = 7; p >= 0; p--)
      for (int d = 0; d < 2; d++)
        if (!halted[d] && tally[d] < limit_now)
          decode_bit(d, v[p], (d == 0) ? LumaBlocksADefault : LumaBlocksBDefault);
  endfunction

  function automatic void predict_byte(logic [7:0] v, logic last);
    report_t r;
    if (await_stuff) begin
      await_stuff = 0;
      if (v == StuffByte) feed_bits(held[7:0]);
      else halted = '{1, 1};
    end else if (v == MarkerByte) begin
      held = v;
      if (last) halted = '{1, 1};
      else await_stuff = 1;
    end else begin
      held = v;
      feed_bits(v);
    end
    if (last) begin
      r.four = tally[0][15:0];
      r.two = tally[1][15:0];
      r.pick = tally[0] > tally[1];
      reports_due.push_back(r);
      start_scan();
    end
  endfunction

  // Length in the upper half, code in the lower half.
  function automatic int code_of(int tbl, int idx);
    int c;
    int k;
    c = 0;
    k = 0;
    for (int len = 1; len <= 16; len++) begin
      for (int j = 0; j < LEN_COUNTS[tbl][len-1]; j++) begin
        if (k == idx) return (len << 16) | c;
        c++;
        k++;
      end
      c = c << 1;
    end
    return 0;
  endfunction

  function automatic void push_code(int tbl, int idx);
    int lc;
    lc = code_of(tbl, idx);
    for (int i = (lc >> 16) - 1; i >= 0; i--) stream_bits.push_back(lc[i]);
  endfunction

  function automatic void push_raw(int n);
    for (int i = 0; i < n; i++) stream_bits.push_back($urandom_range(0, 1));
  endfunction

  function automatic void build_block(int chroma);
    int c;
    int idx;
    int sym;
    int eob;
    bit dense;
    bit ok;
    dense = ($urandom_range(0, 99) < 5);
    eob = 0;
    for (int i = 0; i < 162; i++)
      if (AC_SYMS[chroma][i] == 8'h00) eob = i;
    idx = $urandom_range(0, 11);
    push_code(chroma, idx);
    push_raw(idx);
    c = 0;
    while (c < 63) begin
      ok = 0;
      if (dense || $urandom_range(0, 99) >= 55) begin
        for (int t = 0; t < 8 && !ok; t++) begin
          idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 161) : $urandom_range(0, 15);
          sym = AC_SYMS[chroma][idx];
          ok = (sym != 0) && (c + (sym >> 4) + 1 <= 63);
        end
      end
      if (!ok) begin
        push_code(2 + chroma, eob);
        break;
      end
      push_code(2 + chroma, idx);
      push_raw(sym & 15);
      c += (sym >> 4) + 1;
    end
  endfunction

  // Fills scan_q with one scan, byte stuffing included.
  function automatic void build_scan();
    int kind;
    int luma;
    int pos;
    logic [7:0] v;
    logic [7:0] packed_q[$];
    stream_bits.delete();
    scan_q.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 95) begin
      repeat ($urandom_range(1, 6)) scan_q.push_back($urandom_range(0, 255));
      return;
    end
    luma = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : (($urandom_range(0, 1) == 1) ? 4 : 2);
    repeat ($urandom_range(1, 2))
      for (int b = 0; b < luma + 2; b++) build_block(b >= luma);
    if (kind >= 75 && kind < 85) begin
      pos = $urandom_range(0, stream_bits.size() - 1);
      stream_bits[pos] = ~stream_bits[pos];
    end
    while (stream_bits.size() % 8 != 0) stream_bits.push_back(1'b1);
    for (int i = 0; i < stream_bits.size(); i += 8) begin
      for (int j = 0; j < 8; j++) v[7-j] = stream_bits[i+j];
      packed_q.push_back(v);
    end
    if (kind >= 85 && kind < 90 && packed_q.size() > 1)
      repeat ($urandom_range(1, packed_q.size() - 1)) void'(packed_q.pop_back());
    foreach (packed_q[i]) begin
      scan_q.push_back(packed_q[i]);
      if (packed_q[i] == MarkerByte) scan_q.push_back(StuffByte);
    end
    if (kind >= 90 && kind < 95) begin
      pos = $urandom_range(0, scan_q.size());
      scan_q.insert(pos, $urandom_range(1, 255));
      scan_q.insert(pos, MarkerByte);
    end
  endfunction

  task automatic send_byte(logic [7:0] v, logic last);
    while ($urandom_range(0, 99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    predict_byte(v, last);
  endtask

  task automatic send_scans(int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      build_scan();
      foreach (scan_q[i]) send_byte(scan_q[i], i == scan_q.size() - 1);
      sent += scan_q.size();
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Waits until every expected report has been received, then idles before returning.
  task automatic drain();
    while (reports_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= CfgAddrWidth'(4 * RegMcuLimit);
    pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    limit_now = v;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== v)
      $error("mcu_limit readback: expected %0d, actual %0d", v, prdata[15:0]);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_row(logic [7:0] v, logic last, logic typed = 0,
                                  logic [15:0] four = 0, logic [15:0] two = 0,
                                  logic pick = 0);
    row_t r;
    r.data = v;
    r.last = last;
    r.typed = typed;
    r.rep = '{four, two, pick};
    plan.push_back(r);
  endfunction

  always @(posedge clk) begin
    report_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (reports_due.size() == 0) begin
        $error("report with none expected: %h", m_axis_tdata);
        errors++;
      end else begin
        e = reports_due.pop_front();
        if (m_axis_tdata[15:0] !== e.four) begin
          $error("count_four_luma: expected %0d, actual %0d", e.four, m_axis_tdata[15:0]);
          errors++;
        end
        if (m_axis_tdata[31:16] !== e.two) begin
          $error("count_two_luma: expected %0d, actual %0d", e.two, m_axis_tdata[31:16]);
          errors++;
        end
        if (m_axis_tdata[32] !== e.pick) begin
          $error("is_four_two_zero: expected %0d, actual %0d", e.pick, m_axis_tdata[32]);
          errors++;
        end
      end
    end
  end

  // A long hold-off lets the sender back up into the block.
  initial begin
    holding <= 1'b0;
    wait (hold_go);
    @(posedge clk);
    holding <= 1'b1;
    repeat (6000) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin
    if (holding) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || psel) begin
      quiet <= 0;
    end else if (quiet >= 30000) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int limits[6];
    errors = 0;
    quiet = 0;
    snd_idle = 28;
    rcv_idle = 75;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= 8'd0;
    s_axis_tlast <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= 32'd0;
    limit_now = McuLimitReset;
    start_scan();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Hand-made scans: lone bytes, bad markers, stuffing and one 4:2:2 MCU.
    add_row(8'h00, 1, 1, 0, 0, 0);
    add_row(8'hFF, 1, 1, 0, 0, 0);
    add_row(8'hFF, 0);
    add_row(8'h01, 1, 1, 0, 0, 0);
    add_row(8'hFF, 0);
    add_row(8'hFF, 1, 1, 0, 0, 0);
    add_row(8'hFF, 0);
    add_row(8'h00, 1);
    add_row(8'h7F, 0);
    add_row(8'h80, 0);
    add_row(8'h55, 0);
    add_row(8'hAA, 1);
    add_row(8'h0F, 0);
    add_row(8'hF0, 0);
    add_row(8'h3C, 0);
    add_row(8'hC3, 0);
    add_row(8'hFE, 1);
    add_row(8'h00, 0);
    add_row(8'h00, 0);
    add_row(8'h00, 1);
    add_row(8'h28, 0);
    add_row(8'hA0, 0);
    add_row(8'h0F, 1);
    foreach (plan[i]) begin
      send_byte(plan[i].data, plan[i].last);
      if (plan[i].typed) reports_due[reports_due.size()-1] = plan[i].rep;
    end
    s_axis_tvalid <= 1'b0;

    limits = '{1, 65535, 2, 3, $urandom_range(1, 65535), 10000};
    for (int p = 0; p < 6; p++) begin
      drain();
      write_limit(16'(limits[p]));
      if (p < 2) begin
        snd_idle = 28;
        rcv_idle = 75;
      end else if (p < 4) begin
        snd_idle = 75;
        rcv_idle = 28;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      if (p == 4) hold_go = 1'b1;
      send_scans(95);
    end

    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
src/jpeg_ssd_pkg.sv
src/jpeg_subsampling_detector.sv
dv/testbench.sv
